>>> rtl/core/crt_pkg.sv
// Shared types, codes and a helper function for the command retransmit tracker.
package crt_pkg;

	typedef enum logic [1:0] {
		OP_SEND   = 2'd0,
		OP_TICK   = 2'd1,
		OP_ACK    = 2'd2,
		OP_UPLINK = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		EV_DISPATCH  = 2'd0,
		EV_CONFIRMED = 2'd1,
		EV_EXPIRED   = 2'd2,
		EV_REJECTED  = 2'd3
	} ev_t;

	typedef enum logic [1:0] {
		REG_RETRY_COUNT   = 2'd0,
		REG_RETRY_GAP     = 2'd1,
		REG_PROBE_GAP     = 2'd2,
		REG_PENDING_LIMIT = 2'd3
	} reg_idx_t;

	localparam int MAX_RESULTS = 4;
	localparam logic [2:0] NODE_FIRST = 3'd1;
	localparam logic [2:0] NODE_LAST = 3'd4;
	localparam logic [15:0] SEQ_FIRST = 16'd1;
	localparam int CFG_W = 24;

	typedef struct packed {
		op_t         operation;
		logic [2:0]  node_id;
		logic [15:0] ack_seq;
		logic        request_valid;
		logic [31:0] now_ms;
	} crt_in_t;

	typedef struct packed {
		ev_t         event_res;
		logic [2:0]  event_node;
		logic [15:0] event_seq;
		logic        last;
	} crt_out_t;

	typedef struct packed {
		logic [3:0]  retry_count;
		logic [15:0] retry_gap_ms;
		logic [15:0] probe_gap_ms;
		logic [23:0] pending_limit_ms;
	} crt_cfg_t;

	typedef struct packed {
		logic load;
		logic walk;
		logic finish;
	} crt_ctl_t;

	// True when time now has reached time t under wrapping comparison.
	function automatic logic reached(input logic [31:0] now, input logic [31:0] t);
		logic [31:0] diff;
		diff = now - t;
		return ~diff[31];
	endfunction

endpackage

>>> rtl/core/command_retransmit_tracker_unit.sv
// Top level of the command retransmit tracker with configuration registers.
//
// The block keeps one pending downlink command per node in a table of SLOTS
// slots and reports dispatch, confirmation, expiry and rejection events.
// A transaction is accepted on a rising edge where start is high and busy
// is low; the item port holds the operation and its fields at that edge.
// Every transaction walks the slot table one slot per cycle, then takes a
// final action step; busy is high through both, and a new transaction is
// accepted only in idle. Results appear on result with result_valid high for
// exactly one cycle each; the last result of a transaction has its last field
// set and appears in the cycle in which busy falls. A tick gives up to four
// results, the others one or none. The receiver cannot hold results off, and
// none are buffered. Configuration is written through cfg_write, cfg_index
// and cfg_data; the user must do so only while the block is idle, which the
// block does not enforce. Reset clears all slots, sets the sequence counter
// to one and loads the default register values; no clearing pass is needed.
module command_retransmit_tracker_unit
	import crt_pkg::*;
#(
	parameter int SLOTS = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  crt_in_t          item,
	output crt_out_t         result,
	output logic             result_valid,
	input  logic             cfg_write,
	input  reg_idx_t         cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	crt_cfg_t cfg_q;
	crt_ctl_t ctl;
	logic [IDX_W-1:0] idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.retry_count <= 4'd3;
			cfg_q.retry_gap_ms <= 16'd150;
			cfg_q.probe_gap_ms <= 16'd1000;
			cfg_q.pending_limit_ms <= 24'd30000;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_RETRY_COUNT: cfg_q.retry_count <= cfg_data[3:0];
				REG_RETRY_GAP: cfg_q.retry_gap_ms <= cfg_data[15:0];
				REG_PROBE_GAP: cfg_q.probe_gap_ms <= cfg_data[15:0];
				REG_PENDING_LIMIT: cfg_q.pending_limit_ms <= cfg_data[23:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	crt_ctrl #(
		.SLOTS(SLOTS),
		.IDX_W(IDX_W)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.ctl(ctl),
		.idx(idx)
	);

	crt_dp #(
		.SLOTS(SLOTS),
		.IDX_W(IDX_W)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.idx(idx),
		.item(item),
		.cfg(cfg_q),
		.result(result),
		.result_valid(result_valid)
	);

	a_result_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result issued outside a transaction");

	a_last_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.last) |=> !result_valid)
		else $error("result followed the last result of a transaction");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

endmodule

>>> rtl/core/crt_ctrl.sv
// Controller state machine that sequences the slot walk and the final action.
module crt_ctrl
	import crt_pkg::*;
#(
	parameter int SLOTS = 4,
	parameter int IDX_W = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	output crt_ctl_t         ctl,
	output logic [IDX_W-1:0] idx
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_WALK   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t state_q;
	logic [IDX_W-1:0] idx_q;
	logic idx_end;

	assign idx_end = (idx_q == IDX_W'(SLOTS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (start) state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (idx_end) begin
						state_q <= ST_FINISH;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_FINISH: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign idx = idx_q;
	assign ctl.load = start && (state_q == ST_IDLE);
	assign ctl.walk = (state_q == ST_WALK);
	assign ctl.finish = (state_q == ST_FINISH);

endmodule

>>> rtl/core/crt_dp.sv
// Datapath with the slot table, the search and retry logic and the result register.
module crt_dp
	import crt_pkg::*;
#(
	parameter int SLOTS = 4,
	parameter int IDX_W = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  crt_ctl_t         ctl,
	input  logic [IDX_W-1:0] idx,
	input  crt_in_t          item,
	input  crt_cfg_t         cfg,
	output crt_out_t         result,
	output logic             result_valid
);

	logic        busy_q [SLOTS];
	logic [2:0]  node_q [SLOTS];
	logic [15:0] seq_q [SLOTS];
	logic [3:0]  retries_q [SLOTS];
	logic [31:0] next_q [SLOTS];
	logic [31:0] dead_q [SLOTS];

	crt_in_t item_q;
	logic [15:0] next_seq_q;
	logic hit_q;
	logic free_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [IDX_W-1:0] free_idx_q;
	logic [15:0] hit_seq_q;
	logic hit_due_q;
	logic [2:0] n_q;
	logic pend_valid_q;
	crt_out_t pend_q;
	crt_out_t res_q;
	logic res_valid_q;

	logic rd_busy;
	logic [2:0] rd_node;
	logic [15:0] rd_seq;
	logic [3:0] rd_retries;
	logic [31:0] rd_next;
	logic [31:0] rd_dead;

	logic node_ok;
	logic tk_act;
	logic tk_dead;
	logic tk_due;
	logic tk_emit;
	logic [3:0] ret_dec;
	logic [15:0] tk_gap;
	logic snd_ok;
	logic [IDX_W-1:0] snd_idx;
	logic ack_match;
	logic [15:0] seq_inc;

	logic [IDX_W-1:0] wr_addr;
	logic wr_busy_en;
	logic wr_busy_val;
	logic wr_fields_en;
	logic wr_ret_en;
	logic [3:0] wr_ret_val;
	logic wr_next_en;
	logic [31:0] wr_next_val;

	logic fin_valid;
	crt_out_t fin_res;
	crt_out_t tk_res;

	assign rd_busy = busy_q[idx];
	assign rd_node = node_q[idx];
	assign rd_seq = seq_q[idx];
	assign rd_retries = retries_q[idx];
	assign rd_next = next_q[idx];
	assign rd_dead = dead_q[idx];

	assign node_ok = (item_q.node_id >= NODE_FIRST) && (item_q.node_id <= NODE_LAST);

	assign tk_dead = reached(item_q.now_ms, rd_dead);
	assign tk_due = reached(item_q.now_ms, rd_next);
	assign tk_act = ctl.walk && (item_q.operation == OP_TICK) && rd_busy
		&& (n_q < 3'(MAX_RESULTS));
	assign tk_emit = tk_act && (tk_dead || tk_due);
	assign ret_dec = rd_retries - 4'd1;
	assign tk_gap = ((rd_retries != 4'd0) && (ret_dec != 4'd0)) ? cfg.retry_gap_ms
		: cfg.probe_gap_ms;

	assign snd_idx = hit_q ? hit_idx_q : free_idx_q;
	assign snd_ok = item_q.request_valid && node_ok && (hit_q || free_q);
	assign ack_match = (item_q.ack_seq == 16'd0) || (item_q.ack_seq == hit_seq_q);
	assign seq_inc = next_seq_q + 16'd1;

	always_comb begin
		tk_res.event_res = tk_dead ? EV_EXPIRED : EV_DISPATCH;
		tk_res.event_node = rd_node;
		tk_res.event_seq = rd_seq;
		tk_res.last = 1'b0;
	end

	always_comb begin
		wr_addr = idx;
		wr_busy_en = 1'b0;
		wr_busy_val = 1'b0;
		wr_fields_en = 1'b0;
		wr_ret_en = 1'b0;
		wr_ret_val = ret_dec;
		wr_next_en = 1'b0;
		wr_next_val = item_q.now_ms + {16'd0, tk_gap};
		fin_valid = 1'b0;
		fin_res.event_res = EV_DISPATCH;
		fin_res.event_node = item_q.node_id;
		fin_res.event_seq = next_seq_q;
		fin_res.last = 1'b1;
		if (tk_act) begin
			if (tk_dead) begin
				wr_busy_en = 1'b1;
			end else if (tk_due) begin
				wr_ret_en = (rd_retries != 4'd0);
				wr_next_en = 1'b1;
			end
		end
		if (ctl.finish) begin
			case (item_q.operation)
				OP_SEND: begin
					fin_valid = 1'b1;
					if (snd_ok) begin
						wr_addr = snd_idx;
						wr_busy_en = 1'b1;
						wr_busy_val = 1'b1;
						wr_fields_en = 1'b1;
						wr_ret_en = 1'b1;
						wr_ret_val = cfg.retry_count;
						wr_next_en = 1'b1;
						wr_next_val = item_q.now_ms + {16'd0, cfg.retry_gap_ms};
					end else begin
						fin_res.event_res = EV_REJECTED;
						fin_res.event_seq = 16'd0;
					end
				end
				OP_TICK: begin
					fin_valid = pend_valid_q;
					fin_res = pend_q;
					fin_res.last = 1'b1;
				end
				OP_ACK, OP_UPLINK: begin
					fin_res.event_res = EV_CONFIRMED;
					fin_res.event_seq = hit_seq_q;
					if (node_ok && hit_q) begin
						wr_addr = hit_idx_q;
						wr_next_en = hit_due_q;
						wr_next_val = item_q.now_ms;
						if ((item_q.operation == OP_ACK) && ack_match) begin
							wr_busy_en = 1'b1;
							fin_valid = 1'b1;
						end
					end
				end
				default: fin_valid = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_fields_en) begin
			node_q[wr_addr] <= item_q.node_id;
			seq_q[wr_addr] <= next_seq_q;
			dead_q[wr_addr] <= item_q.now_ms + {8'd0, cfg.pending_limit_ms};
		end
		if (wr_ret_en) retries_q[wr_addr] <= wr_ret_val;
		if (wr_next_en) next_q[wr_addr] <= wr_next_val;
		if (ctl.load) item_q <= item;
		if (ctl.walk) begin
			if (rd_busy && (rd_node == item_q.node_id) && !hit_q) begin
				hit_idx_q <= idx;
				hit_seq_q <= rd_seq;
				hit_due_q <= tk_due;
			end
			if (!rd_busy && !free_q) free_idx_q <= idx;
		end
		if (tk_emit) pend_q <= tk_res;
		if (tk_emit && pend_valid_q) begin
			res_q <= pend_q;
		end else if (fin_valid) begin
			res_q <= fin_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) busy_q[i] <= 1'b0;
			next_seq_q <= SEQ_FIRST;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			n_q <= '0;
			pend_valid_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= (tk_emit && pend_valid_q) || fin_valid;
			if (wr_busy_en) busy_q[wr_addr] <= wr_busy_val;
			if (wr_fields_en) next_seq_q <= (seq_inc == 16'd0) ? SEQ_FIRST : seq_inc;
			if (ctl.load) begin
				hit_q <= 1'b0;
				free_q <= 1'b0;
				n_q <= '0;
				pend_valid_q <= 1'b0;
			end else if (ctl.walk) begin
				if (rd_busy && (rd_node == item_q.node_id)) hit_q <= 1'b1;
				if (!rd_busy) free_q <= 1'b1;
				if (tk_emit) begin
					pend_valid_q <= 1'b1;
					n_q <= n_q + 3'd1;
				end
			end else if (ctl.finish) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	assign result = res_q;
	assign result_valid = res_valid_q;

endmodule
